// ===== hw/rtl/kbsb_pkg.sv =====
// Package with the types, key codes and defaults shared by the scancode buffer.
`default_nettype none

package kbsb_pkg;

  // Default number of entries in the key ring.
  localparam int unsigned KBSB_BUFFER_DEPTH = 16;

  // Width of one stored make code.
  localparam int unsigned KEY_W = 7;

  // Request kinds on the input channel.
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Set-1 make codes that get special handling.
  localparam logic [KEY_W-1:0] KEY_ESC       = 7'h01;
  localparam logic [KEY_W-1:0] KEY_LCTRL     = 7'h1D;
  localparam logic [KEY_W-1:0] KEY_LSHIFT    = 7'h2A;
  localparam logic [KEY_W-1:0] KEY_C         = 7'h2E;
  localparam logic [KEY_W-1:0] KEY_RSHIFT    = 7'h36;
  localparam logic [KEY_W-1:0] KEY_LALT      = 7'h38;
  localparam logic [KEY_W-1:0] KEY_CAPS      = 7'h3A;
  // First function key; it and every code above it are never stored,
  // which also covers F11, F12 and the extended prefix.
  localparam logic [KEY_W-1:0] KEY_FIRST_FN  = 7'h3B;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } kbsb_state_e;

  // Actions decoded from one scancode.
  typedef struct packed {
    logic ctrl_wr;
    logic ctrl_val;
    logic shift_wr;
    logic shift_val;
    logic caps_toggle;
    logic ctrl_c;
    logic store;
  } kbsb_act_t;

endpackage : kbsb_pkg

`default_nettype wire

// ===== hw/rtl/keyboard_scancode_buffer_core.sv =====
// Top level of the keyboard scancode buffer: flags, ring pointers and key RAM.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid_i/in_stall_o  req_type_i, scancode_i
//   out      source     out_valid_o/out_stall_i key_code_o, key_valid_o, ctrl_c_event_o,
//                                               upper_case_o, shift_held_o, ctrl_held_o
//
// A scancode or a read of an empty ring is loaded straight into the output
// register; a read that pops a code first passes the registered key RAM read.
// Reset clears the pointers, the modifier flags and the sequencer; the RAM
// is not cleared and is only read at entries already written.
// A result is held in the output register until taken; a new transaction is
// accepted in the same cycle that the previous result leaves.
`default_nettype none

module keyboard_scancode_buffer_core
  import kbsb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = KBSB_BUFFER_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             req_type_i,
  input  wire logic [7:0]       scancode_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [KEY_W-1:0] key_code_o,
  output logic                  key_valid_o,
  output logic                  ctrl_c_event_o,
  output logic                  upper_case_o,
  output logic                  shift_held_o,
  output logic                  ctrl_held_o
);

  localparam int unsigned PtrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(BUFFER_DEPTH - 1);

  kbsb_state_e      state_q, state_d;
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic             ctrl_q, ctrl_d, shift_q, shift_d, caps_q, caps_d;
  logic             out_valid_q, out_valid_d;
  logic [KEY_W-1:0] key_code_q;
  logic             key_valid_q, ctrl_c_q, upper_q, shift_out_q, ctrl_out_q;

  logic             out_free;
  logic             in_acc;
  logic             acc_scan;
  logic             acc_read;
  logic             ring_empty;
  logic             load_now;
  logic             load_pop;
  logic             ram_rd_en;
  logic [KEY_W-1:0] ram_rd_data;
  kbsb_act_t        act;

  // Scancode decode.
  kbsb_decode u_decode (
    .scancode_i  (scancode_i),
    .ctrl_held_i (ctrl_q),
    .act_o       (act)
  );

  // Key ring storage.
  kbsb_ram #(
    .WIDTH (KEY_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (acc_scan && act.store),
    .wr_addr_i (wptr_q),
    .wr_data_i (scancode_i[KEY_W-1:0]),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (rptr_q),
    .rd_data_o (ram_rd_data)
  );

  assign ring_empty = (rptr_q == wptr_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign acc_scan   = in_acc && (req_type_i == REQ_SCAN);
  assign acc_read   = in_acc && (req_type_i == REQ_READ);

  // Sequencer: next state, handshake and output register loads.
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    ram_rd_en  = 1'b0;
    load_now   = 1'b0;
    load_pop   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = !out_free;
        if (acc_read && !ring_empty) begin
          ram_rd_en = 1'b1;
          state_d   = ST_READ;
        end else if (in_acc) begin
          load_now = 1'b1;
        end
      end
      ST_READ: begin
        load_pop = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Flag and pointer updates.
  always_comb begin
    ctrl_d  = ctrl_q;
    shift_d = shift_q;
    caps_d  = caps_q;
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (acc_scan) begin
      if (act.ctrl_wr) begin
        ctrl_d = act.ctrl_val;
      end
      if (act.shift_wr) begin
        shift_d = act.shift_val;
      end
      if (act.caps_toggle) begin
        caps_d = !caps_q;
      end
      if (act.store) begin
        wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
      end
    end
    if (load_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
  end

  // Output valid tracking.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_now || load_pop) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      ctrl_q      <= 1'b0;
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      ctrl_q      <= ctrl_d;
      shift_q     <= shift_d;
      caps_q      <= caps_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load_now || load_pop) begin
      key_code_q  <= load_pop ? ram_rd_data : '0;
      key_valid_q <= load_pop;
      ctrl_c_q    <= acc_scan && act.ctrl_c;
      upper_q     <= caps_d ^ shift_d;
      shift_out_q <= shift_d;
      ctrl_out_q  <= ctrl_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_code_o     = key_code_q;
  assign key_valid_o    = key_valid_q;
  assign ctrl_c_event_o = ctrl_c_q;
  assign upper_case_o   = upper_q;
  assign shift_held_o   = shift_out_q;
  assign ctrl_held_o    = ctrl_out_q;

  // While a pop waits on the RAM, no new transaction may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> in_stall_o)
    else $error("transaction accepted during a pending pop");

  // A read of a non-empty ring always goes to the RAM wait state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_read && !ring_empty) |=> (state_q == ST_READ))
    else $error("pop did not start a RAM read");

  // A stored key always moves the write pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_scan && act.store) |=> (wptr_q != $past(wptr_q)))
    else $error("write pointer did not advance on store");

  // A popped key and a Ctrl+C event never appear in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(key_valid_o && ctrl_c_event_o))
    else $error("pop and Ctrl+C in one result");

  // A result without a popped key carries a zero code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !key_valid_o) |-> (key_code_o == '0))
    else $error("nonzero key code without a valid key");

endmodule : keyboard_scancode_buffer_core

`default_nettype wire

// ===== hw/rtl/kbsb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module kbsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : kbsb_ram

`default_nettype wire

// ===== hw/rtl/kbsb_decode.sv =====
// Scancode decoder: turns one set-1 byte into flag updates and a store request.
`default_nettype none

module kbsb_decode
  import kbsb_pkg::*;
(
  input  wire logic [7:0] scancode_i,
  input  wire logic       ctrl_held_i,
  output kbsb_act_t       act_o
);

  logic             released;
  logic [KEY_W-1:0] key;
  logic             is_ctrl;
  logic             is_ctrl_c;
  logic             is_shift;
  logic             is_other;

  assign released = scancode_i[7];
  assign key      = scancode_i[KEY_W-1:0];

  // Modifier keys take priority in this order: Ctrl, Ctrl+C, Shift.
  assign is_ctrl   = (key == KEY_LCTRL);
  assign is_ctrl_c = (key == KEY_C) && !released && ctrl_held_i;
  assign is_shift  = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
  assign is_other  = !is_ctrl && !is_ctrl_c && !is_shift;

  // Build the action set. Only make codes of ordinary keys are stored.
  always_comb begin
    act_o             = '0;
    act_o.ctrl_wr     = is_ctrl;
    act_o.ctrl_val    = !released;
    act_o.shift_wr    = is_shift;
    act_o.shift_val   = !released;
    act_o.ctrl_c      = is_ctrl_c;
    act_o.caps_toggle = is_other && !released && (key == KEY_CAPS);
    act_o.store       = is_other && !released && (key > KEY_ESC) && (key < KEY_FIRST_FN) &&
                        (key != KEY_LALT) && (key != KEY_CAPS);
  end

endmodule : kbsb_decode

`default_nettype wire

// ===== bench/kbsb_result_checker.sv =====
// Checker that predicts every scancode buffer result and compares it with the block's output.
module kbsb_result_checker
  import kbsb_pkg::*;
#(
  parameter int unsigned DEPTH = KBSB_BUFFER_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             req_type_i,
  input  logic [7:0]       scancode_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [KEY_W-1:0] key_code_i,
  input  logic             key_valid_i,
  input  logic             ctrl_c_event_i,
  input  logic             upper_case_i,
  input  logic             shift_held_i,
  input  logic             ctrl_held_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o,
  output int               popped_o,
  output int               ctrl_c_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result as the block presents it.
  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic             key_valid;
    logic             ctrl_c;
    logic             upper_case;
    logic             shift_held;
    logic             ctrl_held;
  } key_result_t;

  // Shadow copy of the key ring, its pointers and the modifier flags.
  logic [KEY_W-1:0] ring_q [DEPTH];
  int unsigned      wr_idx;
  int unsigned      rd_idx;
  logic             ctrl_q;
  logic             shift_q;
  logic             caps_q;

  key_result_t      expected_q [$];
  int               fails;
  int               results;
  int               popped;
  int               ctrl_c_count;

  // A make code goes into the ring unless it is a modifier, Caps Lock, Escape,
  // a code at or above the first function key, or zero.
  function automatic logic is_storable(logic [KEY_W-1:0] key);
    return key > KEY_ESC && key < KEY_FIRST_FN && key != KEY_LCTRL &&
           key != KEY_LSHIFT && key != KEY_RSHIFT && key != KEY_LALT &&
           key != KEY_CAPS;
  endfunction

  // Advances the shadow state by one transaction and returns its result.
  function automatic key_result_t apply_request(logic req, logic [7:0] sc);
    key_result_t      res;
    logic             released;
    logic [KEY_W-1:0] key;
    res      = '0;
    released = sc[7];
    key      = sc[KEY_W-1:0];
    if (req == REQ_READ) begin
      // A read pops the oldest code unless the pointers meet.
      if (rd_idx != wr_idx) begin
        res.key_code  = ring_q[rd_idx];
        res.key_valid = 1'b1;
        rd_idx        = (rd_idx + 1) % DEPTH;
      end
    end else if (key == KEY_LCTRL) begin
      ctrl_q = !released;
    end else if (key == KEY_C && !released && ctrl_q) begin
      res.ctrl_c = 1'b1;
    end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
      shift_q = !released;
    end else begin
      // Only the Caps Lock make toggles; its release does nothing.
      if (sc == {1'b0, KEY_CAPS}) begin
        caps_q = !caps_q;
      end
      // A full ring is not guarded: the write pointer catches up with the read pointer and the unread codes are lost.
      if (!released && is_storable(key)) begin
        ring_q[wr_idx] = key;
        wr_idx         = (wr_idx + 1) % DEPTH;
      end
    end
    res.upper_case = caps_q ^ shift_q;
    res.shift_held = shift_q;
    res.ctrl_held  = ctrl_q;
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  function automatic void compare_field(string name, logic [KEY_W-1:0] want,
                                        logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // Results are checked before the input of the same edge is predicted, since
  // a result leaving now always belongs to an earlier transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    key_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        ring_q[i] = '0;
      end
      wr_idx       = 0;
      rd_idx       = 0;
      ctrl_q       = 1'b0;
      shift_q      = 1'b0;
      caps_q       = 1'b0;
      fails        = 0;
      results      = 0;
      popped       = 0;
      ctrl_c_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction waiting: key_code %0h", key_code_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          compare_field("key_code", want.key_code, key_code_i);
          compare_field("key_valid", want.key_valid, key_valid_i);
          compare_field("ctrl_c_event", want.ctrl_c, ctrl_c_event_i);
          compare_field("upper_case", want.upper_case, upper_case_i);
          compare_field("shift_held", want.shift_held, shift_held_i);
          compare_field("ctrl_held", want.ctrl_held, ctrl_held_i);
          results++;
          popped       += want.key_valid;
          ctrl_c_count += want.ctrl_c;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(apply_request(req_type_i, scancode_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    results_o    <= results;
    popped_o     <= popped;
    ctrl_c_o     <= ctrl_c_count;
  end

endmodule

// ===== bench/tb_keyboard_scancode_buffer_core.sv =====
// Testbench top for the keyboard scancode buffer: clock, reset, stimulus and verdict.
module tb_keyboard_scancode_buffer_core
  import kbsb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int END_SLACK    = 16;

  // Codes the block treats specially that the package does not name.
  localparam logic [KEY_W-1:0] KEY_F11       = 7'h57;
  localparam logic [KEY_W-1:0] KEY_F12       = 7'h58;
  localparam logic [KEY_W-1:0] KEY_TOP       = 7'h7F;
  localparam logic [7:0]       SC_EXT_PREFIX = 8'hE0;
  localparam logic [KEY_W-1:0] KEY_NONE      = 7'h00;
  localparam logic [KEY_W-1:0] KEY_FIRST_ORD = 7'h02;
  localparam logic [KEY_W-1:0] KEY_LAST_ORD  = 7'h39;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             req_type  = REQ_SCAN;
  logic [7:0]       scancode  = 8'h00;
  logic             out_stall = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [KEY_W-1:0] key_code_o;
  logic             key_valid_o;
  logic             ctrl_c_event_o;
  logic             upper_case_o;
  logic             shift_held_o;
  logic             ctrl_held_o;

  int fail_count;
  int pending;
  int results;
  int popped;
  int ctrl_c_seen;
  int items_sent  = 0;
  int calm_items  = 0;
  int cycle_count = 0;

  keyboard_scancode_buffer_core #(
    .BUFFER_DEPTH(KBSB_BUFFER_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type),
    .scancode_i     (scancode),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .key_code_o     (key_code_o),
    .key_valid_o    (key_valid_o),
    .ctrl_c_event_o (ctrl_c_event_o),
    .upper_case_o   (upper_case_o),
    .shift_held_o   (shift_held_o),
    .ctrl_held_o    (ctrl_held_o)
  );

  kbsb_result_checker #(
    .DEPTH(KBSB_BUFFER_DEPTH)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall_o),
    .req_type_i     (req_type),
    .scancode_i     (scancode),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall),
    .key_code_i     (key_code_o),
    .key_valid_i    (key_valid_o),
    .ctrl_c_event_i (ctrl_c_event_o),
    .upper_case_i   (upper_case_o),
    .shift_held_i   (shift_held_o),
    .ctrl_held_i    (ctrl_held_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .popped_o       (popped),
    .ctrl_c_o       (ctrl_c_seen)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keyboard_scancode_buffer_core: mismatch");
      $finish;
    end
  end

  // Receiver stalls: mostly short bursts, a few long ones, and calm stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    int stall_left;
    int calm_left;
    int pick;
    if (!rst_ni) begin
      stall_left = 0;
      calm_left  = 0;
      out_stall <= 1'b0;
    end else if (calm_left != 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        calm_left = $urandom_range(20, 80);
      end else if (pick < 30) begin
        stall_left = $urandom_range(1, 3);
      end else if (pick < 33) begin
        stall_left = $urandom_range(10, 40);
      end
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] make_code(logic [KEY_W-1:0] key);
    return {1'b0, key};
  endfunction

  function automatic logic [7:0] break_code(logic [KEY_W-1:0] key);
    return {1'b1, key};
  endfunction

  // Random key that lands in the ring when pressed, unless it is C while Ctrl is held.
  function automatic logic [KEY_W-1:0] plain_key();
    logic [KEY_W-1:0] key;
    do begin
      key = KEY_W'($urandom_range(KEY_FIRST_ORD, KEY_LAST_ORD));
    end while (key == KEY_LCTRL || key == KEY_LSHIFT || key == KEY_RSHIFT ||
               key == KEY_LALT || key == KEY_CAPS);
    return key;
  endfunction

  // Presents one transaction, waits for it to be taken, then maybe idles.
  task automatic send_item(input logic req, input logic [7:0] sc);
    int gap;
    int pick;
    in_valid <= 1'b1;
    req_type <= req;
    scancode <= sc;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    items_sent++;
    gap = 0;
    if (calm_items != 0) begin
      calm_items--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        calm_items = $urandom_range(20, 50);
      end else if (pick >= 55 && pick < 90) begin
        gap = $urandom_range(1, 3);
      end else if (pick >= 90) begin
        gap = $urandom_range(8, 30);
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_key(input logic [7:0] sc);
    send_item(REQ_SCAN, sc);
  endtask

  task automatic send_read();
    send_item(REQ_READ, 8'($urandom_range(0, 255)));
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  initial begin
    int pick;
    int count;
    int next_drain;
    logic [KEY_W-1:0] key;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty reads, every class of code, the modifiers and Ctrl+C.
    send_item(REQ_READ, 8'hFF);
    send_key(make_code(KEY_NONE));
    send_key(make_code(KEY_ESC));
    send_key(make_code(KEY_FIRST_ORD));
    send_key(make_code(KEY_LAST_ORD));
    send_key(make_code(KEY_FIRST_FN));
    send_key(make_code(KEY_TOP));
    send_key(make_code(KEY_F11));
    send_key(make_code(KEY_F12));
    send_key(make_code(KEY_LALT));
    send_key(SC_EXT_PREFIX);
    send_key(break_code(KEY_TOP));
    send_key(break_code(KEY_FIRST_ORD));
    send_key(make_code(KEY_LCTRL));
    send_key(make_code(KEY_C));
    send_key(break_code(KEY_LCTRL));
    send_key(make_code(KEY_C));
    send_key(make_code(KEY_LSHIFT));
    send_key(make_code(KEY_CAPS));
    send_key(break_code(KEY_CAPS));
    send_key(break_code(KEY_LSHIFT));
    send_key(make_code(KEY_RSHIFT));
    send_key(break_code(KEY_RSHIFT));
    repeat (4) send_item(REQ_READ, 8'h00);
    wait_drained();

    // Random: mostly well-formed typing with modifiers, plus noise.
    next_drain = items_sent + $urandom_range(60, 140);
    while (items_sent < RANDOM_ITEMS + 27) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        count = $urandom_range(1, 5);
        repeat (count) begin
          key = plain_key();
          send_key(make_code(key));
          if ($urandom_range(0, 1) == 1) begin
            send_key(break_code(key));
          end
        end
      end else if (pick < 40) begin
        key = ($urandom_range(0, 1) == 1) ? KEY_LSHIFT : KEY_RSHIFT;
        send_key(make_code(key));
        count = $urandom_range(1, 3);
        repeat (count) send_key(make_code(plain_key()));
        send_key(break_code(($urandom_range(0, 3) == 0) ? KEY_CAPS : key));
        send_key(break_code(key));
      end else if (pick < 50) begin
        send_key(make_code(KEY_LCTRL));
        if ($urandom_range(0, 2) == 0) begin
          send_key(make_code(plain_key()));
        end
        send_key(make_code(KEY_C));
        send_key(break_code(KEY_C));
        send_key(break_code(KEY_LCTRL));
      end else if (pick < 55) begin
        send_key(make_code(KEY_CAPS));
        send_key(break_code(KEY_CAPS));
      end else if (pick < 80) begin
        count = $urandom_range(1, 6);
        repeat (count) send_read();
      end else if (pick < 85) begin
        // A burst of codes that can wrap the ring over unread entries.
        count = $urandom_range(14, 20);
        repeat (count) send_key(make_code(plain_key()));
      end else begin
        count = $urandom_range(1, 4);
        repeat (count) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
      if (items_sent >= next_drain) begin
        wait_drained();
        next_drain = items_sent + $urandom_range(60, 140);
      end
    end

    wait_drained();
    repeat (END_SLACK) @(posedge clk_i);

    $display("Run covered %0d transactions and %0d results, %0d codes popped, %0d Ctrl+C events.",
             items_sent, results, popped, ctrl_c_seen);
    if (fail_count == 0) begin
      $display("keyboard_scancode_buffer_core: match");
    end else begin
      $display("keyboard_scancode_buffer_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/kbsb_pkg.sv
hw/rtl/kbsb_ram.sv
hw/rtl/kbsb_decode.sv
hw/rtl/keyboard_scancode_buffer_core.sv
bench/kbsb_result_checker.sv
bench/tb_keyboard_scancode_buffer_core.sv
